/* src/twm_pkg.sv */
// ----------------------------------------------------------------------------
// twm_pkg
// shared types and codes of the timeline wrap mapper
// ----------------------------------------------------------------------------
package twm_pkg;

	// default widths
	localparam int TIME_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 12;

	// speed factor register width (signed q4.12 at the default)
	localparam int FACTOR_W = 16;

	// configuration register index width
	localparam int CFG_IDX_W = 3;

	// request kinds
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_STOP  = 2'd2;
	localparam logic [1:0] REQ_PAUSE = 2'd3;

	// wrap modes, any other code acts as clamp
	localparam logic [1:0] WRAP_CLAMP  = 2'd0;
	localparam logic [1:0] WRAP_REPEAT = 2'd1;
	localparam logic [1:0] WRAP_MIRROR = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIME_OFFSET  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_FACTOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DURATION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRE_WRAP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POST_WRAP    = 3'd4;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL,
		ST_SCALE,
		ST_PLAN,
		ST_DIV,
		ST_FINISH,
		ST_DONE
	} state_t;

	// fix-up applied to a remainder after division
	typedef enum logic [1:0] {
		FIN_ADD1,
		FIN_NEG,
		FIN_TRI
	} fin_op_t;

endpackage

/* src/timeline_wrap_mapper.sv */
// ----------------------------------------------------------------------------
// timeline_wrap_mapper
// maps a parent time to a local animation time with clamp, repeat and
// mirror wrapping at both ends of the timeline
// ----------------------------------------------------------------------------
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: parent_time; tuser: req_type, parent_present
// m_*       out  m_tvalid/m_tready  tdata: local_time;  tuser: is_paused, is_started
// cfg_*     in   cfg_we             cfg_index, cfg_wdata
//
// start, stop, pause and non-running ticks settle when taken and go straight to
// the done state; a running tick steps through diff, multiply, scale, plan,
// divide and finish: one shared adder does the offset subtract, an 18-step
// shift-add multiply and a TIME_BITS+1 step restoring division for the wrap
// remainder; results whose wrap needs no remainder skip divide and finish
// arst_n clears the timeline state and loads the register defaults
// a request is taken whenever the sequencer is idle; a stalled result holds
// in the output register and the next result waits for it to drain
//
module timeline_wrap_mapper
	import twm_pkg::*;
#(
	parameter int TIME_BITS        = TIME_BITS_DEF,
	parameter int FACTOR_FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((TIME_BITS+7)/8)*8-1:0]        s_tdata,   // parent_time
	input  logic [2:0]                           s_tuser,   // req_type[1:0], parent_present
	// result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((TIME_BITS+7)/8)*8-1:0]        m_tdata,   // local_time
	output logic [1:0]                           m_tuser,   // is_paused, is_started
	// configuration writes
	input  logic                                 cfg_we,
	input  logic [CFG_IDX_W-1:0]                 cfg_index,
	input  logic [(TIME_BITS>FACTOR_W ? TIME_BITS : FACTOR_W)-1:0] cfg_wdata
);

	localparam int TB    = TIME_BITS;
	localparam int TDW   = ((TIME_BITS + 7) / 8) * 8;
	localparam int AW    = TB + 2;               // shared adder width
	localparam int DW    = TB + 1;               // parent minus offset
	localparam int MUL_W = FACTOR_W + 2;         // factor register, holds 1.0 at any frac
	localparam int PW    = AW + MUL_W;           // full product
	localparam int NW    = TB + 1;               // dividend and divisor width
	localparam int CNT_W = $clog2(TB + 2);

	localparam logic signed [PW-1:0] E_MAX = (PW'(1) << (TB - 1)) - PW'(1);
	localparam logic signed [PW-1:0] E_MIN = -E_MAX - PW'(1);

	// configuration registers
	logic signed [TB-1:0]    time_offset_q;
	logic signed [MUL_W-1:0] speed_factor_q;
	logic [TB-2:0]           max_duration_q;
	logic [1:0]              pre_wrap_q;
	logic [1:0]              post_wrap_q;

	// timeline state
	logic signed [TB-1:0] current_time_q;
	logic                 started_q;
	logic                 paused_q;

	// sequencer
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;

	// datapath registers
	logic signed [TB-1:0] parent_q;
	logic signed [DW-1:0] diff_q;
	logic signed [AW-1:0] hi_q;       // product accumulator, upper part
	logic [MUL_W-1:0]     lo_q;       // multiplier bits, then product lower part
	logic signed [TB-1:0] elapsed_q;
	logic [NW-1:0]        num_q;
	logic [NW-1:0]        dvs_q;
	logic [NW-1:0]        rem_q;
	fin_op_t              fin_op_q;

	// output register
	logic                 out_valid_q;
	logic [TB-1:0]        out_time_q;
	logic                 out_paused_q;
	logic                 out_started_q;

	// shared adder
	logic signed [AW-1:0] add_a, add_b, add_y;
	logic                 add_sub;

	// request fields
	logic [1:0]           req_type;
	logic                 parent_present;
	logic signed [TB-1:0] parent_time;
	logic                 accept;
	logic                 tick_run;
	logic                 out_free;

	assign req_type       = s_tuser[1:0];
	assign parent_present = s_tuser[2];
	assign parent_time    = s_tdata[TB-1:0];
	assign accept         = s_tvalid && s_tready;
	assign tick_run       = (req_type == REQ_TICK) && parent_present && started_q && !paused_q;
	assign out_free       = !out_valid_q || m_tready;

	assign add_y = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);

	// scaling: floor shift of the product, then saturate to signed time
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] prod_sh;
	logic signed [TB-1:0] elapsed_d;

	always_comb begin
		prod    = {hi_q, lo_q};
		prod_sh = prod >>> FACTOR_FRAC_BITS;
		if (prod_sh > E_MAX) begin
			elapsed_d = E_MAX[TB-1:0];
		end else if (prod_sh < E_MIN) begin
			elapsed_d = E_MIN[TB-1:0];
		end else begin
			elapsed_d = prod_sh[TB-1:0];
		end
	end

	// wrap plan: either a direct value or a remainder with a fix-up
	logic [NW-1:0]        d_ext;
	logic [NW-1:0]        d2_ext;
	logic signed [NW-1:0] e_ext;
	logic [NW-1:0]        mag;
	logic                 plan_div;
	logic [NW-1:0]        plan_num;
	logic [NW-1:0]        plan_dvs;
	fin_op_t              plan_op;
	logic [NW-1:0]        plan_val;

	assign d_ext  = {2'b00, max_duration_q};
	assign d2_ext = {1'b0, max_duration_q, 1'b0};
	assign e_ext  = NW'(elapsed_q);
	assign mag    = NW'(-e_ext);

	// x holds the time above the duration when above is set
	always_comb begin
		logic [NW-1:0] x;
		logic          above;
		plan_div = 1'b0;
		plan_num = mag;
		plan_dvs = d_ext;
		plan_op  = FIN_NEG;
		plan_val = '0;
		above    = 1'b0;
		x        = mag;
		if (max_duration_q == '0) begin
			plan_val = '0;
		end else if (e_ext > $signed(d_ext)) begin
			above = 1'b1;
			x     = e_ext;
		end else if (elapsed_q < 0) begin
			if (pre_wrap_q == WRAP_REPEAT) begin
				plan_div = 1'b1;
				plan_num = mag;
				plan_dvs = d_ext;
				plan_op  = FIN_NEG;
			end else if (pre_wrap_q == WRAP_MIRROR) begin
				if (mag <= d_ext) begin
					plan_val = mag;
				end else begin
					above = 1'b1;
					x     = mag;
				end
			end else begin
				plan_val = '0;
			end
		end else begin
			plan_val = e_ext;
		end

		if (above) begin
			if (post_wrap_q == WRAP_REPEAT) begin
				plan_div = 1'b1;
				plan_num = x - NW'(1);
				plan_dvs = d_ext;
				plan_op  = FIN_ADD1;
			end else if (post_wrap_q == WRAP_MIRROR) begin
				if (x <= d2_ext) begin
					plan_val = d2_ext - x;
				end else if (pre_wrap_q == WRAP_REPEAT) begin
					// mirrored below zero, then repeated up
					plan_div = 1'b1;
					plan_num = x - d2_ext;
					plan_dvs = d_ext;
					plan_op  = FIN_NEG;
				end else if (pre_wrap_q == WRAP_MIRROR) begin
					// triangle wave of period twice the duration
					plan_div = 1'b1;
					plan_num = x;
					plan_dvs = d2_ext;
					plan_op  = FIN_TRI;
				end else begin
					plan_val = '0;
				end
			end else begin
				plan_val = d_ext;
			end
		end
	end

	// remainder fix-up
	logic [NW-1:0] fin_val;

	always_comb begin
		case (fin_op_q)
			FIN_ADD1: fin_val = rem_q + NW'(1);
			FIN_NEG:  fin_val = (rem_q == '0) ? '0 : d_ext - rem_q;
			FIN_TRI:  fin_val = (rem_q <= d_ext) ? rem_q : d2_ext - rem_q;
			default:  fin_val = rem_q;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = tick_run ? ST_DIFF : ST_DONE;
				end
			end
			ST_DIFF: state_d = ST_MUL;
			ST_MUL: begin
				if (cnt_q == CNT_W'(MUL_W - 1)) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: state_d = ST_PLAN;
			ST_PLAN:  state_d = plan_div ? ST_DIV : ST_DONE;
			ST_DIV: begin
				if (cnt_q == CNT_W'(NW - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and adder operand selection
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		add_a    = '0;
		add_b    = '0;
		add_sub  = 1'b0;
		case (state_q)
			ST_DIFF: begin
				add_a   = AW'(parent_q);
				add_b   = AW'(time_offset_q);
				add_sub = 1'b1;
			end
			ST_MUL: begin
				// last multiplier bit carries negative weight
				add_a   = hi_q;
				add_b   = lo_q[0] ? AW'(diff_q) : '0;
				add_sub = lo_q[0] && (cnt_q == CNT_W'(MUL_W - 1));
			end
			ST_DIV: begin
				add_a   = {1'b0, rem_q[NW-2:0], num_q[NW-1]};
				add_b   = AW'(dvs_q);
				add_sub = 1'b1;
			end
			default: begin
				add_a   = '0;
				add_b   = '0;
				add_sub = 1'b0;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDW'(out_time_q);
	assign m_tuser  = {out_started_q, out_paused_q};

	// control and timeline state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			current_time_q <= '0;
			started_q      <= 1'b0;
			paused_q       <= 1'b0;
			out_valid_q    <= 1'b0;
			time_offset_q  <= '0;
			speed_factor_q <= MUL_W'(1) << FACTOR_FRAC_BITS;
			max_duration_q <= '1;
			pre_wrap_q     <= WRAP_CLAMP;
			post_wrap_q    <= WRAP_CLAMP;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					REG_TIME_OFFSET:  time_offset_q  <= cfg_wdata[TB-1:0];
					REG_SPEED_FACTOR: speed_factor_q <= MUL_W'($signed(cfg_wdata[FACTOR_W-1:0]));
					REG_MAX_DURATION: max_duration_q <= cfg_wdata[TB-2:0];
					REG_PRE_WRAP:     pre_wrap_q     <= cfg_wdata[1:0];
					REG_POST_WRAP:    post_wrap_q    <= cfg_wdata[1:0];
					default: ;
				endcase
			end

			// requests that settle at once
			if (accept) begin
				case (req_type)
					REQ_TICK: begin
						if (!parent_present) begin
							current_time_q <= '0;
						end
					end
					REQ_START: begin
						if (paused_q) begin
							paused_q <= 1'b0;
						end else if (parent_present) begin
							current_time_q <= parent_time;
							started_q      <= 1'b1;
						end
					end
					REQ_STOP: begin
						started_q <= 1'b0;
						paused_q  <= 1'b0;
					end
					default: paused_q <= 1'b1;
				endcase
			end

			// step counter for multiply and divide
			if (state_q == ST_MUL || state_q == ST_DIV) begin
				cnt_q <= (state_d == state_q) ? cnt_q + CNT_W'(1) : '0;
			end else begin
				cnt_q <= '0;
			end

			if (state_q == ST_PLAN && !plan_div) begin
				current_time_q <= plan_val[TB-1:0];
			end
			if (state_q == ST_FINISH) begin
				current_time_q <= fin_val[TB-1:0];
			end

			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			parent_q <= parent_time;
		end
		case (state_q)
			ST_DIFF: begin
				diff_q <= add_y[DW-1:0];
				hi_q   <= '0;
				lo_q   <= speed_factor_q;
			end
			ST_MUL: begin
				hi_q <= {add_y[AW-1], add_y[AW-1:1]};
				lo_q <= {add_y[0], lo_q[MUL_W-1:1]};
			end
			ST_SCALE: elapsed_q <= elapsed_d;
			ST_PLAN: begin
				num_q    <= plan_num;
				dvs_q    <= plan_dvs;
				fin_op_q <= plan_op;
				rem_q    <= '0;
			end
			ST_DIV: begin
				num_q <= {num_q[NW-2:0], 1'b0};
				if (!add_y[AW-1]) begin
					rem_q <= add_y[NW-1:0];
				end else begin
					rem_q <= {rem_q[NW-2:0], num_q[NW-1]};
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_time_q    <= current_time_q;
					out_paused_q  <= paused_q;
					out_started_q <= started_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// partial remainder stays below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < dvs_q && dvs_q != '0))
		else $error("remainder not below divisor");

	// an accepted request always leaves idle
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("request accepted but sequencer stayed idle");

	// a wrapped time lies on the timeline
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |=>
		(current_time_q >= 0 && $unsigned(current_time_q) <= TB'(max_duration_q)))
		else $error("wrapped time outside timeline");

	// a pending result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> (out_valid_q && $stable(out_time_q)))
		else $error("pending result lost");

	// multiply step count stays in range
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (cnt_q < CNT_W'(MUL_W)))
		else $error("multiply counter overrun");
`endif

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the timeline wrap mapper: a scoreboard predicts
// local time, pause and start flags per request under changing register
// settings, with random gaps on the request side and stalls on the result side
// ----------------------------------------------------------------------------
module tb_top;
	import twm_pkg::*;

	localparam int TB_TIME_BITS = TIME_BITS_DEF;
	localparam int TB_FRAC_BITS = FRAC_BITS_DEF;
	localparam int DATA_W       = ((TB_TIME_BITS + 7) / 8) * 8;
	localparam int WDATA_W      = TB_TIME_BITS > FACTOR_W ? TB_TIME_BITS : FACTOR_W;
	localparam longint UNITY    = 64'sd1 <<< TB_FRAC_BITS;

	// one request as it goes onto the request stream
	typedef struct {
		logic [1:0]               kind;
		logic                     present;
		logic [TB_TIME_BITS-1:0]  parent;
	} tl_req_t;

	// one result as it leaves the result stream
	typedef struct {
		logic [TB_TIME_BITS-1:0]  local_time;
		logic                     paused;
		logic                     started;
	} tl_result_t;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      s_tvalid  = 1'b0;
	logic                      s_tready;
	logic [DATA_W-1:0]         s_tdata   = '0;  // parent_time
	logic [2:0]                s_tuser   = '0;  // req_type[1:0], parent_present
	logic                      m_tvalid;
	logic                      m_tready  = 1'b0;
	logic [DATA_W-1:0]         m_tdata;         // local_time
	logic [1:0]                m_tuser;         // is_paused, is_started
	logic                      cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [WDATA_W-1:0]        cfg_wdata = '0;

	timeline_wrap_mapper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// bench copy of the registers, at their reset values
	longint     tl_offset = 0;
	longint     tl_speed  = UNITY;
	longint     tl_dur    = (64'sd1 <<< (TB_TIME_BITS - 1)) - 1;
	logic [1:0] tl_pre    = WRAP_CLAMP;
	logic [1:0] tl_post   = WRAP_CLAMP;

	// bench copy of the timeline state
	longint     cur_time  = 0;
	logic       running   = 1'b0;
	logic       on_hold   = 1'b0;

	tl_req_t    req_backlog[$];   // requests not yet offered
	tl_result_t due_results[$];   // predicted results, oldest first
	tl_req_t    in_flight;        // request currently offered on the stream
	int         errors       = 0;
	int         gap_left     = 0;
	int         stall_left   = 0;
	int         src_idle_pct = 0;
	int         sink_idle_pct = 0;

	// -------------------------------------------------------------------------
	// prediction
	// -------------------------------------------------------------------------

	// remainder that is never negative
	function automatic longint pos_mod(longint x, longint d);
		longint r;
		r = x % d;
		return r < 0 ? r + d : r;
	endfunction

	// scaled elapsed time: floor of diff * factor / 2^frac, saturated
	function automatic longint scaled_elapsed(longint parent);
		longint diff, e, lim;
		lim  = 64'sd1 <<< (TB_TIME_BITS - 1);
		diff = parent - tl_offset;
		e    = (diff * tl_speed) >>> TB_FRAC_BITS;
		if (e > lim - 1)
			e = lim - 1;
		if (e < -lim)
			e = -lim;
		return e;
	endfunction

	// fold a time past the end back onto the timeline (e > d > 0)
	function automatic longint fold_past_end(longint e, longint d);
		longint t;
		if (tl_post == WRAP_REPEAT)
			return ((e - 1) % d) + 1;
		if (tl_post == WRAP_MIRROR) begin
			if (e <= 2 * d)
				return 2 * d - e;
			// bounced below zero, the pre mode takes over
			if (tl_pre == WRAP_REPEAT)
				return pos_mod(2 * d - e, d);
			if (tl_pre != WRAP_MIRROR)
				return 0;
			// mirror at both ends is a triangle wave
			t = e % (2 * d);
			return t <= d ? t : 2 * d - t;
		end
		return d;
	endfunction

	function automatic longint wrapped_time(longint e);
		if (tl_dur == 0)
			return 0;
		if (e > tl_dur)
			return fold_past_end(e, tl_dur);
		if (e < 0) begin
			if (tl_pre == WRAP_REPEAT)
				return pos_mod(e, tl_dur);
			if (tl_pre == WRAP_MIRROR)
				return (-e <= tl_dur) ? -e : fold_past_end(-e, tl_dur);
			return 0;
		end
		return e;
	endfunction

	// apply one accepted request to the timeline and queue its result
	task automatic advance_timeline(input tl_req_t r);
		tl_result_t res;
		case (r.kind)
			REQ_TICK: begin
				if (!r.present)
					cur_time = 0;
				else if (running && !on_hold)
					cur_time = wrapped_time(scaled_elapsed($signed(r.parent)));
			end
			REQ_START: begin
				// a start while paused only resumes
				if (on_hold)
					on_hold = 1'b0;
				else if (r.present) begin
					cur_time = $signed(r.parent);
					running  = 1'b1;
				end
			end
			REQ_STOP: begin
				running = 1'b0;
				on_hold = 1'b0;
			end
			default: on_hold = 1'b1;
		endcase
		res.local_time = cur_time[TB_TIME_BITS-1:0];
		res.paused     = on_hold;
		res.started    = running;
		due_results.push_back(res);
	endtask

	// -------------------------------------------------------------------------
	// request driver
	// -------------------------------------------------------------------------
	always @(posedge clk) begin
		tl_req_t nxt;
		logic    free;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left = 0;
		end else begin
			free = !s_tvalid;
			// request taken at this edge: predict it now
			if (s_tvalid && s_tready) begin
				advance_timeline(in_flight);
				free = 1'b1;
			end
			if (free) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (req_backlog.size() != 0 &&
					$urandom_range(0, 99) < src_idle_pct) begin
					// idle burst, with the further idle cycles counted down in gap_left
					gap_left = $urandom_range(0, 12);
					s_tvalid <= 1'b0;
				end else if (req_backlog.size() != 0) begin
					nxt       = req_backlog.pop_front();
					in_flight = nxt;
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.parent;
					s_tuser  <= {nxt.present, nxt.kind};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// -------------------------------------------------------------------------
	// result monitor and checker
	// -------------------------------------------------------------------------
	always @(posedge clk) begin
		tl_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result local_time %0d paused %0b started %0b",
						$time, $signed(m_tdata[TB_TIME_BITS-1:0]), m_tuser[0], m_tuser[1]);
					errors++;
				end else begin
					want = due_results.pop_front();
					if (m_tdata[TB_TIME_BITS-1:0] !== want.local_time) begin
						$display("%0t: local_time expected %0d actual %0d", $time,
							$signed(want.local_time), $signed(m_tdata[TB_TIME_BITS-1:0]));
						errors++;
					end
					if (m_tuser[0] !== want.paused) begin
						$display("%0t: is_paused expected %0b actual %0b", $time,
							want.paused, m_tuser[0]);
						errors++;
					end
					if (m_tuser[1] !== want.started) begin
						$display("%0t: is_started expected %0b actual %0b", $time,
							want.started, m_tuser[1]);
						errors++;
					end
				end
			end
			// stall bursts, counted down in stall_left
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 99) < sink_idle_pct) begin
				stall_left = $urandom_range(0, 12);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// -------------------------------------------------------------------------
	// stimulus
	// -------------------------------------------------------------------------

	function automatic void queue_req(logic [1:0] kind, logic present,
		logic [TB_TIME_BITS-1:0] parent);
		tl_req_t r;
		r.kind    = kind;
		r.present = present;
		r.parent  = parent;
		req_backlog.push_back(r);
	endfunction

	// mostly ticks on a running timeline, aimed around the wrap points
	function automatic tl_req_t random_request();
		tl_req_t     r;
		int unsigned pick;
		longint      span, target, delta;
		logic [63:0] raw;
		pick = $urandom_range(0, 99);
		if (pick < 72)
			r.kind = REQ_TICK;
		else if (pick < 84)
			r.kind = REQ_START;
		else if (pick < 92)
			r.kind = REQ_PAUSE;
		else
			r.kind = REQ_STOP;
		r.present = ($urandom_range(0, 9) != 0);
		pick = $urandom_range(0, 9);
		if (pick < 2) begin
			r.parent = $urandom;
		end else if (pick == 2) begin
			case ($urandom_range(0, 3))
				0: r.parent = {1'b1, {(TB_TIME_BITS-1){1'b0}}};
				1: r.parent = {1'b0, {(TB_TIME_BITS-1){1'b1}}};
				2: r.parent = '0;
				default: r.parent = '1;
			endcase
		end else begin
			// target elapsed within a few durations either side of zero
			span   = 3 * tl_dur + 8;
			raw    = {$urandom, $urandom};
			target = longint'(raw % 64'(2 * span + 1)) - span;
			delta  = (tl_speed != 0) ? target * UNITY / tl_speed : target;
			r.parent = TB_TIME_BITS'(tl_offset + delta);
		end
		return r;
	endfunction

	// register write on the port, one per call; the bench copy follows
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WDATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_TIME_OFFSET:  tl_offset = $signed(val[TB_TIME_BITS-1:0]);
			REG_SPEED_FACTOR: tl_speed  = $signed(val[FACTOR_W-1:0]);
			REG_MAX_DURATION: tl_dur    = val[TB_TIME_BITS-2:0];
			REG_PRE_WRAP:     tl_pre    = val[1:0];
			REG_POST_WRAP:    tl_post   = val[1:0];
			default: ;
		endcase
	endtask

	// wait until every request is taken and every result is back
	task automatic drain_timeline();
		while (req_backlog.size() != 0 || s_tvalid || due_results.size() != 0)
			@(posedge clk);
	endtask

	// program all registers, start the timeline and run random requests;
	// unused high bits of the narrow registers carry noise
	task automatic run_phase(input logic [31:0] off, input logic [15:0] spd,
		input logic [30:0] dur, input logic [1:0] pre, input logic [1:0] post,
		input int n_items, input logic calm);
		logic [31:0] noise;
		noise = $urandom;
		set_reg(REG_TIME_OFFSET, off);
		set_reg(REG_SPEED_FACTOR, {noise[31:16], spd});
		set_reg(REG_MAX_DURATION, {noise[0], dur});
		set_reg(REG_PRE_WRAP, {noise[29:0], pre});
		set_reg(REG_POST_WRAP, {noise[31:2], post});
		if (calm) begin
			src_idle_pct  = 0;
			sink_idle_pct = 0;
		end else begin
			src_idle_pct  = 8 * $urandom_range(0, 3);
			sink_idle_pct = 8 * $urandom_range(0, 3);
		end
		queue_req(REQ_STOP, 1'b1, $urandom);
		queue_req(REQ_START, 1'b1, $urandom);
		repeat (n_items)
			req_backlog.push_back(random_request());
		drain_timeline();
	endtask

	initial begin
		logic [15:0] spd;
		logic [30:0] dur;
		int          pick;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests at the register defaults
		src_idle_pct  = 10;
		sink_idle_pct = 10;
		queue_req(REQ_TICK,  1'b0, 32'd55);          // no parent zeroes time
		queue_req(REQ_TICK,  1'b1, 32'd77);          // stopped, unchanged
		queue_req(REQ_START, 1'b0, 32'd99);          // start with no parent does nothing
		queue_req(REQ_START, 1'b1, 32'd1000);        // latch parent time
		queue_req(REQ_TICK,  1'b1, 32'd5000);
		queue_req(REQ_TICK,  1'b1, -32'sd5);         // below zero clamps
		queue_req(REQ_TICK,  1'b1, 32'h7fff_ffff);   // exactly at the duration
		queue_req(REQ_TICK,  1'b1, 32'h8000_0000);
		queue_req(REQ_PAUSE, 1'b1, 32'd0);
		queue_req(REQ_TICK,  1'b1, 32'd77);          // paused, unchanged
		queue_req(REQ_START, 1'b1, 32'd9);           // resume only
		queue_req(REQ_TICK,  1'b0, 32'd123);
		queue_req(REQ_PAUSE, 1'b0, 32'd0);
		queue_req(REQ_STOP,  1'b0, 32'd0);
		queue_req(REQ_PAUSE, 1'b1, 32'd0);           // pause while stopped
		queue_req(REQ_START, 1'b1, 32'd4);           // clears the pause only
		queue_req(REQ_START, 1'b1, 32'h8000_0000);
		queue_req(REQ_TICK,  1'b1, 32'd12345);
		queue_req(REQ_STOP,  1'b1, 32'd0);
		queue_req(REQ_START, 1'b1, 32'hffff_ffff);
		drain_timeline();

		// special settings: extremes, mirror both ends, mirror then repeat,
		// unused mode code, zero duration, negative and tiny speed
		run_phase(32'h8000_0000, 16'h7fff, 31'h7fff_ffff, WRAP_MIRROR, WRAP_MIRROR, 40, 1'b0);
		run_phase(32'h7fff_ffff, 16'h8000, 31'd1, WRAP_REPEAT, WRAP_REPEAT, 40, 1'b0);
		run_phase(32'd0, 16'd4096, 31'd100, WRAP_REPEAT, WRAP_MIRROR, 50, 1'b0);
		run_phase(-32'sd50, 16'd2048, 31'd37, 2'd3, 2'd3, 40, 1'b0);
		run_phase(32'd123, 16'hf000, 31'd0, WRAP_MIRROR, WRAP_REPEAT, 30, 1'b0);
		run_phase($urandom, 16'd4096, 31'd10, WRAP_MIRROR, WRAP_MIRROR, 50, 1'b0);
		run_phase(32'd7, 16'd1, 31'd50, WRAP_CLAMP, WRAP_MIRROR, 40, 1'b0);

		// random settings, the last phase without idling
		for (int ph = 0; ph < 9; ph++) begin
			case ($urandom_range(0, 5))
				0: spd = 16'd4096;
				1: spd = 16'hf000;
				2: spd = 16'd2048;
				3: spd = 16'd8192;
				default: spd = 16'($urandom);
			endcase
			pick = $urandom_range(0, 9);
			if (pick < 6)
				dur = 31'($urandom_range(1, 64));
			else if (pick < 8)
				dur = 31'($urandom_range(1, 100000));
			else if (pick == 8)
				dur = 31'($urandom);
			else
				dur = 31'($urandom_range(0, 2));
			run_phase($urandom, spd, dur, 2'($urandom_range(0, 3)),
				2'($urandom_range(0, 3)), 80, ph == 8);
		end

		// catch any stray result
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#1000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
